[hdl/sphts_pkg.sv]
// Shared types and constants for the SPH time-step minimum reduction.
package sphts_pkg;

  typedef struct packed {
    logic [31:0] smoothing_length;
    logic [31:0] sonic_speed;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    logic        last_particle;
    logic        cs_zero;
  } item_t;

  localparam logic [31:0] STEP_INF = 32'hFFFF_FFFF;

  localparam logic [1:0] LIM_MAX     = 2'd0;
  localparam logic [1:0] LIM_COURANT = 2'd1;
  localparam logic [1:0] LIM_ACCEL   = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COURANT_FACTOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEP       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_COURANT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_ACCEL   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_THRESH   = 3'd4;

  localparam logic [15:0] RST_COURANT_FACTOR = 16'd4096;
  localparam logic [31:0] RST_MAX_STEP       = 32'd655360;
  localparam logic [31:0] RST_ACCEL_THRESH   = 32'd1;

endpackage

[hdl/sphts_front.sv]
// Input stage: takes a particle transfer and classifies it into a queue item.
module sphts_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [159:0]       s_tdata,
  input  logic               s_tlast,
  output logic               q_valid,
  input  logic               q_ready,
  output sphts_pkg::item_t   q_item
);

  logic             held;
  sphts_pkg::item_t item;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign s_tready = !held || q_ready;
  assign q_valid  = held;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      item.smoothing_length <= s_tdata[31:0];
      item.sonic_speed      <= s_tdata[63:32];
      item.mag_x            <= magnitude(s_tdata[95:64]);
      item.mag_y            <= magnitude(s_tdata[127:96]);
      item.mag_z            <= magnitude(s_tdata[159:128]);
      item.last_particle    <= s_tlast;
      item.cs_zero          <= (s_tdata[63:32] == 32'd0);
    end
  end

endmodule

[hdl/sphts_fifo.sv]
// Two-entry queue between the input stage and the arithmetic sequencer.
module sphts_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  sphts_pkg::item_t wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output sphts_pkg::item_t rd_item
);

  sphts_pkg::item_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) entries[wr_ptr] <= wr_item;
  end

endmodule

[hdl/sphts_back.sv]
// Sequencer with shared multiplier, divider and square root, minima and result register.
module sphts_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sphts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                           cfg_data,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  sphts_pkg::item_t                      q_item,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [31:0]                           m_tdata,
  output logic [1:0]                            m_tuser
);

  localparam int NW0 = (48 + FRACTION_BITS > 32 + 2 * FRACTION_BITS) ?
                       48 + FRACTION_BITS : 32 + 2 * FRACTION_BITS;
  localparam int NW  = (NW0 > 64) ? NW0 : 64;
  localparam int DW  = 44;
  localparam int CW  = $clog2(NW);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_CLOAD = 4'd2;
  localparam logic [3:0] ST_CDIV  = 4'd3;
  localparam logic [3:0] ST_CUPD  = 4'd4;
  localparam logic [3:0] ST_ACHK  = 4'd5;
  localparam logic [3:0] ST_ASQ1  = 4'd6;
  localparam logic [3:0] ST_ALOAD = 4'd7;
  localparam logic [3:0] ST_ADIV  = 4'd8;
  localparam logic [3:0] ST_SLOAD = 4'd9;
  localparam logic [3:0] ST_ASQ2  = 4'd10;
  localparam logic [3:0] ST_AUPD  = 4'd11;
  localparam logic [3:0] ST_FIN   = 4'd12;

  logic [3:0]       state;
  logic [CW-1:0]    cnt;
  logic [1:0]       mcnt;
  sphts_pkg::item_t cur;

  logic [15:0] courant_factor;
  logic [31:0] max_step;
  logic        enable_courant;
  logic        enable_acceleration;
  logic [31:0] accel_threshold;

  logic [31:0] min_courant_step;
  logic [31:0] min_accel_step;

  logic [63:0] n2;
  logic [47:0] cprod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic [NW-1:0] dnum;
  logic [NW-1:0] dquo;
  logic [DW-1:0] drem;
  logic [DW-1:0] ddiv;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          dge;

  logic [63:0] sx;
  logic [31:0] rt;
  logic [33:0] sr;
  logic [35:0] rem4;
  logic [35:0] trial;
  logic        sge;

  logic [31:0] cstep;
  logic [63:0] ratio;
  logic [31:0] best;
  logic [1:0]  code;
  logic        out_free;

  assign q_ready  = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    unique case (mcnt)
      2'd0:    begin mul_a = cur.mag_x; mul_b = cur.mag_x; end
      2'd1:    begin mul_a = cur.mag_y; mul_b = cur.mag_y; end
      2'd2:    begin mul_a = cur.mag_z; mul_b = cur.mag_z; end
      default: begin mul_a = {16'd0, courant_factor}; mul_b = cur.smoothing_length; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  assign rem_sh  = {drem, dnum[NW-1]};
  assign dge     = (rem_sh >= {1'b0, ddiv});
  assign rem_sub = rem_sh - {1'b0, ddiv};

  assign rem4  = {sr, sx[63:62]};
  assign trial = {2'b00, rt, 2'b01};
  assign sge   = (rem4 >= trial);

  assign cstep = ((dquo >> 32) != '0) ? sphts_pkg::STEP_INF : dquo[31:0];
  assign ratio = ((dquo >> 64) != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : dquo[63:0];

  always_comb begin
    logic [31:0] cs_s;
    logic [31:0] ac_s;
    logic [1:0]  cc;
    logic [1:0]  ac;
    cs_s = min_courant_step;
    cc   = sphts_pkg::LIM_COURANT;
    if (min_courant_step == sphts_pkg::STEP_INF || min_courant_step > max_step) begin
      cs_s = max_step;
      cc   = sphts_pkg::LIM_MAX;
    end
    ac_s = min_accel_step;
    ac   = sphts_pkg::LIM_ACCEL;
    if (min_accel_step == sphts_pkg::STEP_INF || min_accel_step > max_step) begin
      ac_s = max_step;
      ac   = sphts_pkg::LIM_MAX;
    end
    best = max_step;
    code = sphts_pkg::LIM_MAX;
    if (enable_courant) begin
      best = cs_s;
      code = cc;
    end
    if (enable_acceleration && (!enable_courant || ac_s < best)) begin
      best = ac_s;
      code = ac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      m_tvalid            <= 1'b0;
      min_courant_step    <= sphts_pkg::STEP_INF;
      min_accel_step      <= sphts_pkg::STEP_INF;
      courant_factor      <= sphts_pkg::RST_COURANT_FACTOR;
      max_step            <= sphts_pkg::RST_MAX_STEP;
      enable_courant      <= 1'b1;
      enable_acceleration <= 1'b1;
      accel_threshold     <= sphts_pkg::RST_ACCEL_THRESH;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sphts_pkg::CFG_COURANT_FACTOR: courant_factor      <= cfg_data[15:0];
          sphts_pkg::CFG_MAX_STEP:       max_step            <= cfg_data;
          sphts_pkg::CFG_ENABLE_COURANT: enable_courant      <= cfg_data[0];
          sphts_pkg::CFG_ENABLE_ACCEL:   enable_acceleration <= cfg_data[0];
          sphts_pkg::CFG_ACCEL_THRESH:   accel_threshold     <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && !(state == ST_FIN && cur.last_particle)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            n2    <= 64'd0;
            mcnt  <= 2'd0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt != 2'd3) begin
            n2 <= n2 + prod;
          end else begin
            cprod <= prod[47:0];
            state <= cur.cs_zero ? ST_ACHK : ST_CLOAD;
          end
        end
        ST_CLOAD: begin
          dnum  <= NW'(cprod) << FRACTION_BITS;
          ddiv  <= {cur.sonic_speed, 12'd0};
          drem  <= '0;
          dquo  <= '0;
          cnt   <= '0;
          state <= ST_CDIV;
        end
        ST_CDIV, ST_ADIV: begin
          dnum <= dnum << 1;
          drem <= dge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          dquo <= {dquo[NW-2:0], dge};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) state <= (state == ST_CDIV) ? ST_CUPD : ST_SLOAD;
        end
        ST_CUPD: begin
          if (cstep < min_courant_step) min_courant_step <= cstep;
          state <= ST_ACHK;
        end
        ST_ACHK: begin
          sx  <= n2;
          rt  <= '0;
          sr  <= '0;
          cnt <= '0;
          state <= (n2 > {32'd0, accel_threshold}) ? ST_ASQ1 : ST_FIN;
        end
        ST_ASQ1, ST_ASQ2: begin
          sx  <= sx << 2;
          sr  <= sge ? 34'(rem4 - trial) : rem4[33:0];
          rt  <= {rt[30:0], sge};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(31)) state <= (state == ST_ASQ1) ? ST_ALOAD : ST_AUPD;
        end
        ST_ALOAD: begin
          dnum  <= NW'(cur.smoothing_length) << (2 * FRACTION_BITS);
          ddiv  <= DW'(rt);
          drem  <= '0;
          dquo  <= '0;
          cnt   <= '0;
          state <= ST_ADIV;
        end
        ST_SLOAD: begin
          sx    <= ratio;
          rt    <= '0;
          sr    <= '0;
          cnt   <= '0;
          state <= ST_ASQ2;
        end
        ST_AUPD: begin
          if (rt < min_accel_step) min_accel_step <= rt;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!cur.last_particle) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_tvalid         <= 1'b1;
            m_tdata          <= best;
            m_tuser          <= code;
            min_courant_step <= sphts_pkg::STEP_INF;
            min_accel_step   <= sphts_pkg::STEP_INF;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_minima_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && cur.last_particle && out_free) |=>
      (min_courant_step == sphts_pkg::STEP_INF && min_accel_step == sphts_pkg::STEP_INF))
    else $error("minima not cleared after a result");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= max_step))
    else $error("time step above max_step");

  a_limiter_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == sphts_pkg::LIM_MAX || m_tuser == sphts_pkg::LIM_COURANT ||
                  m_tuser == sphts_pkg::LIM_ACCEL))
    else $error("bad limiter code");

  a_max_code_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == sphts_pkg::LIM_MAX) |-> (m_tdata == max_step))
    else $error("max limiter with a step other than max_step");

endmodule

[hdl/sph_timestep_min_reduction.sv]
// Top level of the SPH time-step minimum reduction.
//
// Particles arrive on the s_ stream, one transfer each: tdata holds smoothing
// length, sound speed and the three acceleration components, tlast marks the
// last particle of a set. Only the last particle produces a transfer on the m_
// stream: tdata is the chosen time step and tuser the limiter code.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must do so only while the block is idle, which it does not enforce.
// An input stage and a two-entry queue take particles while the sequencer is
// busy. The sequencer handles one particle at a time with one multiplier, one
// bit-serial divider and one two-bit-per-cycle square root. It sums the squared
// acceleration components, divides for the Courant step unless the sound speed
// is zero and, above the threshold, takes a square root, a division and a square
// root for the acceleration step. The dividend is NW bits wide, 64 by default.
// The result sits in an output register; while the receiver stalls, up to three
// further particles are buffered before s_tready falls.
// Reset restores the register defaults and sets both minima to infinity.
module sph_timestep_min_reduction #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [159:0]                      s_tdata,  // smoothing_length, sonic_speed, accel_x, accel_y, accel_z
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,  // time_step
  output logic [1:0]                        m_tuser,  // limiter
  input  logic                              cfg_we,
  input  logic [sphts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic             f_valid;
  logic             f_ready;
  sphts_pkg::item_t f_item;
  logic             b_valid;
  logic             b_ready;
  sphts_pkg::item_t b_item;

  sphts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  sphts_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  sphts_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_item    (b_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[test/tb_top.sv]
// Testbench for the SPH time-step minimum reduction: random and directed particle sets.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [sphts_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic [31:0] step;
    logic [1:0]  lim;
  } step_result_t;

  step_result_t step_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  logic [15:0] courant_r;
  logic [31:0] max_step_r;
  logic en_courant_r, en_accel_r;
  logic [31:0] thresh_r;
  logic [31:0] min_courant, min_accel;

  always #5 clk = ~clk;

  sph_timestep_min_reduction dut (.*);

  function automatic logic [63:0] div_shift_sat(logic [63:0] n, logic [63:0] d, int s,
                                                logic [63:0] limit);
    logic [127:0] q;
    q = ({64'd0, n} << s) / {64'd0, d};
    return (q > {64'd0, limit}) ? limit : q[63:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= {64'd0, x}) r = t[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] sq(logic [31:0] v);
    logic [63:0] m;
    m = v[31] ? {32'd0, -v} : {32'd0, v};
    if (v == 32'h8000_0000) m = 64'h8000_0000;
    return m * m;
  endfunction

  function automatic void predict_particle(logic [159:0] d, logic last);
    logic [63:0] h, cs, st, amag, ratio;
    logic [65:0] n2;
    logic [31:0] best, s;
    logic [1:0] code, c;
    logic have;
    h = d[31:0];
    cs = d[63:32];
    n2 = sq(d[95:64]) + sq(d[127:96]) + sq(d[159:128]);
    if (cs != 0) begin
      st = div_shift_sat(courant_r * h, cs << 12, 16, 64'hFFFF_FFFF);
      if (st < min_courant) min_courant = st[31:0];
    end
    if (n2 > thresh_r) begin
      amag = isqrt(n2[63:0]);
      ratio = div_shift_sat(h, amag, 32, '1);
      st = isqrt(ratio);
      if (st > 64'hFFFF_FFFF) st = 64'hFFFF_FFFF;
      if (st < min_accel) min_accel = st[31:0];
    end
    if (!last) return;
    best = max_step_r;
    code = sphts_pkg::LIM_MAX;
    have = 1'b0;
    if (en_courant_r) begin
      s = min_courant;
      c = sphts_pkg::LIM_COURANT;
      if (s == sphts_pkg::STEP_INF || s > max_step_r) begin
        s = max_step_r;
        c = sphts_pkg::LIM_MAX;
      end
      best = s;
      code = c;
      have = 1'b1;
    end
    if (en_accel_r) begin
      s = min_accel;
      c = sphts_pkg::LIM_ACCEL;
      if (s == sphts_pkg::STEP_INF || s > max_step_r) begin
        s = max_step_r;
        c = sphts_pkg::LIM_MAX;
      end
      if (!have || s < best) begin
        best = s;
        code = c;
      end
    end
    min_courant = sphts_pkg::STEP_INF;
    min_accel = sphts_pkg::STEP_INF;
    step_q.push_back({best, code});
  endfunction

  task automatic send_particle(logic [31:0] h, logic [31:0] cs, logic [31:0] ax,
                               logic [31:0] ay, logic [31:0] az, logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {az, ay, ax, cs, h};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_particle({az, ay, ax, cs, h}, last);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (step_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [sphts_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sphts_pkg::CFG_COURANT_FACTOR: courant_r = val[15:0];
      sphts_pkg::CFG_MAX_STEP:       max_step_r = val;
      sphts_pkg::CFG_ENABLE_COURANT: en_courant_r = val[0];
      sphts_pkg::CFG_ENABLE_ACCEL:   en_accel_r = val[0];
      sphts_pkg::CFG_ACCEL_THRESH:   thresh_r = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(255);
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly moderate magnitudes, sometimes an edge-case word, for the acceleration components.
  function automatic logic [31:0] rand_accel();
    logic [31:0] v;
    v = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(32'h0004_0000);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic random_sets(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      int len;
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        logic [31:0] h, cs;
        h = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(32'h0010_0000);
        cs = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(32'h0040_0000);
        send_particle(h, cs, rand_accel(), rand_accel(), rand_accel(), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_particle(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 1'b1);
    send_particle(32'h0001_0000, 0, 0, 0, 0, 1'b1);
    send_particle('1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_particle(0, '1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0);
    send_particle('1, '1, '1, '1, '1, 1'b1);
    send_particle(32'h0000_1000, 32'h0010_0000, 32'h0000_0100, 0, 0, 1'b0);
    send_particle(32'h0001_0000, 32'h0000_8000, 0, 32'h0002_0000, 0, 1'b1);
    send_particle(32'h0004_0000, 32'h0004_0000, 0, 0, 32'h0004_0000, 1'b1);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(sphts_pkg::CFG_COURANT_FACTOR, 32'hFFFF);
    write_reg(sphts_pkg::CFG_MAX_STEP, '1);
    write_reg(sphts_pkg::CFG_ACCEL_THRESH, 0);
    random_sets(40);
    drain();
    write_reg(sphts_pkg::CFG_COURANT_FACTOR, 0);
    write_reg(sphts_pkg::CFG_MAX_STEP, 0);
    write_reg(sphts_pkg::CFG_ACCEL_THRESH, '1);
    random_sets(30);
    drain();
    write_reg(sphts_pkg::CFG_COURANT_FACTOR, 32'(sphts_pkg::RST_COURANT_FACTOR));
    write_reg(sphts_pkg::CFG_MAX_STEP, sphts_pkg::RST_MAX_STEP);
    write_reg(sphts_pkg::CFG_ACCEL_THRESH, sphts_pkg::RST_ACCEL_THRESH);
    for (int m = 0; m < 4; m++) begin
      write_reg(sphts_pkg::CFG_ENABLE_COURANT, 32'(m[0]));
      write_reg(sphts_pkg::CFG_ENABLE_ACCEL, 32'(m[1]));
      random_sets(30);
      drain();
    end
    write_reg(sphts_pkg::CFG_ENABLE_COURANT, 1);
    write_reg(sphts_pkg::CFG_ENABLE_ACCEL, 1);
  endtask

  task automatic test_random_traffic();
    int sends[4] = '{0, 65, 0, 19};
    int stalls[4] = '{0, 0, 65, 19};
    for (int p = 0; p < 4; p++) begin
      send_idle = sends[p];
      recv_stall = stalls[p];
      write_reg(sphts_pkg::CFG_COURANT_FACTOR, $urandom_range(16'hFFFF));
      write_reg(sphts_pkg::CFG_MAX_STEP, $urandom);
      random_sets(100);
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_stall);
      if (m_tvalid && m_tready) begin
        if (step_q.size() == 0) begin
          $error("unexpected result time_step=%0h limiter=%0d", m_tdata, m_tuser);
          errors++;
        end else begin
          step_result_t e;
          e = step_q.pop_front();
          if (m_tdata !== e.step) begin
            $error("time_step expected %0h actual %0h", e.step, m_tdata);
            errors++;
          end
          if (m_tuser !== e.lim) begin
            $error("limiter expected %0d actual %0d", e.lim, m_tuser);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    courant_r = sphts_pkg::RST_COURANT_FACTOR;
    max_step_r = sphts_pkg::RST_MAX_STEP;
    en_courant_r = 1'b1;
    en_accel_r = 1'b1;
    thresh_r = sphts_pkg::RST_ACCEL_THRESH;
    min_courant = sphts_pkg::STEP_INF;
    min_accel = sphts_pkg::STEP_INF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_traffic();
    drain();
    if (errors == 0 && step_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

[files.f]
hdl/sphts_pkg.sv
hdl/sphts_front.sv
hdl/sphts_fifo.sv
hdl/sphts_back.sv
hdl/sph_timestep_min_reduction.sv
test/tb_top.sv
